FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond)

`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: rtl/alpd_pkg.sv
// ----------------------------------------------------------------------------
// alpd_pkg
// Shared constants, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package alpd_pkg;

   localparam int MAX_ENTRIES_DEF = 64;

   localparam int DATA_W    = 32;
   localparam int OP_W      = 2;
   localparam int POS_W     = 7;
   localparam int CNT_OUT_W = 7;
   localparam int CAP_W     = 7;
   localparam int ST_W      = 2;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

   localparam logic [OP_W-1:0] OP_PUSH   = 2'd0;
   localparam logic [OP_W-1:0] OP_POP    = 2'd1;
   localparam logic [OP_W-1:0] OP_DELETE = 2'd2;
   localparam logic [OP_W-1:0] OP_READ   = 2'd3;

   localparam logic [ST_W-1:0] ST_OK    = 2'd0;
   localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
   localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
   localparam logic [ST_W-1:0] ST_RANGE = 2'd3;

   // register index, taken from paddr[2]
   localparam logic REG_CAPACITY = 1'b0;

   typedef struct packed {
      logic load;
      logic set_status;
      logic push;
      logic pop;
      logic fetch;
      logic capture;
      logic shift_step;
      logic shrink;
      logic emit;
   } alpd_cmd_type;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            err;
      logic            more;
      logic            pend;
   } alpd_sts_type;

endpackage

`default_nettype wire

FILE: rtl/alpd_ram.sv
// ----------------------------------------------------------------------------
// alpd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module alpd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/alpd_ctrl.sv
// ----------------------------------------------------------------------------
// alpd_ctrl
// Sequencer: accepts a request, steps the datapath through the operation
// and the delete shift loop, then issues the response.
// ----------------------------------------------------------------------------
`default_nettype none

module alpd_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire alpd_pkg::alpd_sts_type sts,
   output alpd_pkg::alpd_cmd_type      cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_EXEC   = 3'd1;
   localparam logic [2:0] S_CAPT   = 3'd2;
   localparam logic [2:0] S_SHIFT  = 3'd3;
   localparam logic [2:0] S_FINISH = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.set_status = 1'b1;
            if (sts.err) begin
               state_in = S_FINISH;
            end else begin
               unique case (sts.op) inside
                  alpd_pkg::OP_PUSH: begin
                     cmd.push = 1'b1;
                     state_in = S_FINISH;
                  end
                  alpd_pkg::OP_POP: begin
                     cmd.pop  = 1'b1;
                     state_in = S_CAPT;
                  end
                  alpd_pkg::OP_DELETE, alpd_pkg::OP_READ: begin
                     cmd.fetch = 1'b1;
                     state_in  = S_CAPT;
                  end
               endcase
            end
         end
         S_CAPT: begin
            cmd.capture = 1'b1;
            if (sts.op == alpd_pkg::OP_DELETE) begin
               state_in = S_SHIFT;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_SHIFT: begin
            cmd.shift_step = 1'b1;
            if (!sts.more && !sts.pend) begin
               cmd.shrink = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_FINISH: begin
            cmd.emit = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = reset || (state_ff != S_IDLE);

endmodule

`default_nettype wire

FILE: rtl/alpd_dp.sv
// ----------------------------------------------------------------------------
// alpd_dp
// Datapath: request latch, entry count, entry RAM, shift pointers and
// response registers.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module alpd_dp #(
   parameter int MAX_ENTRIES = alpd_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire alpd_pkg::alpd_cmd_type              cmd,
   output alpd_pkg::alpd_sts_type                   sts,
   input  wire logic        [alpd_pkg::CAP_W-1:0]   capacity,
   input  wire logic        [alpd_pkg::OP_W-1:0]    req_opcode,
   input  wire logic signed [alpd_pkg::DATA_W-1:0]  req_push_value,
   input  wire logic        [alpd_pkg::POS_W-1:0]   req_position,
   output logic                                     rsp_strobe,
   output logic             [alpd_pkg::ST_W-1:0]    rsp_status,
   output logic signed      [alpd_pkg::DATA_W-1:0]  rsp_read_value,
   output logic             [alpd_pkg::CNT_OUT_W-1:0] rsp_entry_count,
   output logic                                     rsp_is_empty,
   output logic                                     rsp_is_full
);

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (CW > alpd_pkg::POS_W) ? CW : alpd_pkg::POS_W;

   logic [alpd_pkg::OP_W-1:0]      op_ff;
   logic [alpd_pkg::DATA_W-1:0]    val_ff;
   logic [alpd_pkg::POS_W-1:0]     pos_ff;
   logic [alpd_pkg::ST_W-1:0]      status_ff;
   logic [alpd_pkg::DATA_W-1:0]    data_ff;
   logic [CW-1:0]                  count_ff;
   logic [CW-1:0]                  count_in;
   logic [CW-1:0]                  rd_idx_ff;
   logic [CW-1:0]                  rd_idx_in;
   logic [AW-1:0]                  wr_idx_ff;
   logic [AW-1:0]                  wr_idx_in;
   logic                           pend_ff;
   logic                           pend_in;

   logic                           rsp_strobe_ff;
   logic [alpd_pkg::ST_W-1:0]      rsp_status_ff;
   logic [alpd_pkg::DATA_W-1:0]    rsp_data_ff;
   logic [alpd_pkg::CNT_OUT_W-1:0] rsp_count_ff;
   logic                           rsp_empty_ff;
   logic                           rsp_full_ff;

   logic [XW-1:0]                  cap_x;
   logic [XW-1:0]                  cap_eff_x;
   logic [XW-1:0]                  count_x;
   logic [XW-1:0]                  pos_x;
   logic                           full;
   logic                           empty;
   logic                           range_err;
   logic                           more;
   logic [alpd_pkg::ST_W-1:0]      code;

   logic                           ram_wr_en;
   logic [AW-1:0]                  ram_wr_addr;
   logic [alpd_pkg::DATA_W-1:0]    ram_wr_data;
   logic                           ram_rd_en;
   logic [AW-1:0]                  ram_rd_addr;
   logic [alpd_pkg::DATA_W-1:0]    ram_rd_data;

   // effective capacity saturates at the store depth
   assign cap_x     = XW'(capacity);
   assign cap_eff_x = (cap_x > XW'(MAX_ENTRIES)) ? XW'(MAX_ENTRIES) : cap_x;
   assign count_x   = XW'(count_ff);
   assign pos_x     = XW'(pos_ff);
   assign full      = (count_x >= cap_eff_x);
   assign empty     = (count_ff == '0);
   assign range_err = (pos_ff == '0) || (pos_x > count_x);
   assign more      = (rd_idx_ff < count_ff);

   always_comb begin
      code = alpd_pkg::ST_OK;
      unique case (op_ff) inside
         alpd_pkg::OP_PUSH: begin
            if (full) begin
               code = alpd_pkg::ST_FULL;
            end
         end
         alpd_pkg::OP_POP: begin
            if (empty) begin
               code = alpd_pkg::ST_EMPTY;
            end
         end
         alpd_pkg::OP_DELETE, alpd_pkg::OP_READ: begin
            if (range_err) begin
               code = alpd_pkg::ST_RANGE;
            end
         end
      endcase
   end

   assign sts.op   = op_ff;
   assign sts.err  = (code != alpd_pkg::ST_OK);
   assign sts.more = more;
   assign sts.pend = pend_ff;

   always_comb begin
      count_in    = count_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      pend_in     = pend_ff;
      ram_wr_en   = 1'b0;
      ram_wr_addr = wr_idx_ff;
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = rd_idx_ff[AW-1:0];
      if (cmd.push) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = count_ff[AW-1:0];
         ram_wr_data = val_ff;
         count_in    = count_ff + 1'b1;
      end
      if (cmd.pop) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = AW'(count_ff - 1'b1);
         count_in    = count_ff - 1'b1;
      end
      if (cmd.fetch) begin
         ram_rd_en   = 1'b1;
         ram_rd_addr = AW'(pos_x - 1'b1);
         rd_idx_in   = CW'(pos_x);
         wr_idx_in   = AW'(pos_x - 1'b1);
         pend_in     = 1'b0;
      end
      if (cmd.shift_step) begin
         pend_in = more;
         if (more) begin
            ram_rd_en = 1'b1;
            rd_idx_in = rd_idx_ff + 1'b1;
         end
         if (pend_ff) begin
            ram_wr_en = 1'b1;
            wr_idx_in = wr_idx_ff + 1'b1;
         end
      end
      if (cmd.shrink) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      wr_idx_ff <= wr_idx_in;
      if (cmd.load) begin
         op_ff  <= req_opcode;
         val_ff <= req_push_value;
         pos_ff <= req_position;
      end
      if (cmd.set_status) begin
         status_ff <= code;
         data_ff   <= '0;
      end
      if (cmd.capture) begin
         data_ff <= ram_rd_data;
      end
      if (cmd.emit) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= data_ff;
         rsp_count_ff  <= alpd_pkg::CNT_OUT_W'(count_ff);
         rsp_empty_ff  <= empty;
         rsp_full_ff   <= full;
      end
   end

   alpd_ram #(
      .WIDTH (alpd_pkg::DATA_W),
      .DEPTH (MAX_ENTRIES)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_read_value  = rsp_data_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;
   assign rsp_is_full     = rsp_full_ff;

   `ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CW'(MAX_ENTRIES))
   `ASSERT_IMPLIES(a_push_room, clock, reset, cmd.push, !full)
   `ASSERT_IMPLIES(a_shift_wr_below_count, clock, reset, cmd.shift_step && pend_ff, CW'(wr_idx_ff) < count_ff)
   `ASSERT_IMPLIES(a_shift_wr_behind_rd, clock, reset, cmd.shift_step && pend_ff, CW'(wr_idx_ff) < rd_idx_ff)

endmodule

`default_nettype wire

FILE: rtl/array_list_push_pop_delete_top.sv
// ----------------------------------------------------------------------------
// array_list_push_pop_delete_top
// Packed list of signed words with push, pop, delete-at-position and read.
// ----------------------------------------------------------------------------
// After accept a request enters S_EXEC; push or any failed request then goes
// to S_FINISH, pop and read via S_CAPT, delete via S_CAPT and the S_SHIFT
// loop. The shift moves one entry per cycle through the
// single-port-pair RAM. busy drops as rsp_strobe rises, so a new request may
// start in that cycle. Results cannot be stalled. Synchronous reset empties
// the list and sets capacity to 64; RAM contents are not cleared.
`default_nettype none

module array_list_push_pop_delete_top #(
   parameter int MAX_ENTRIES = alpd_pkg::MAX_ENTRIES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  start,
   output logic                                       busy,
   input  wire logic        [alpd_pkg::OP_W-1:0]      req_opcode,
   input  wire logic signed [alpd_pkg::DATA_W-1:0]    req_push_value,
   input  wire logic        [alpd_pkg::POS_W-1:0]     req_position,
   output logic                                       rsp_strobe,
   output logic             [alpd_pkg::ST_W-1:0]      rsp_status,
   output logic signed      [alpd_pkg::DATA_W-1:0]    rsp_read_value,
   output logic             [alpd_pkg::CNT_OUT_W-1:0] rsp_entry_count,
   output logic                                       rsp_is_empty,
   output logic                                       rsp_is_full,
   input  wire logic                                  psel,
   input  wire logic                                  penable,
   input  wire logic                                  pwrite,
   input  wire logic        [alpd_pkg::CSR_AW-1:0]    paddr,
   input  wire logic        [alpd_pkg::CSR_DW-1:0]    pwdata,
   output logic             [alpd_pkg::CSR_DW-1:0]    prdata,
   output logic                                       pready
);

   logic [alpd_pkg::CAP_W-1:0] capacity_ff;
   logic [alpd_pkg::CAP_W-1:0] capacity_in;
   logic                       cap_sel;
   logic                       cap_wr;

   alpd_pkg::alpd_cmd_type cmd;
   alpd_pkg::alpd_sts_type sts;

   assign pready  = 1'b1;
   assign cap_sel = (paddr[2] == alpd_pkg::REG_CAPACITY);
   assign cap_wr  = psel && penable && pwrite && pready && cap_sel;

   assign capacity_in = cap_wr ? pwdata[alpd_pkg::CAP_W-1:0] : capacity_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= alpd_pkg::CAP_RESET;
      end else begin
         capacity_ff <= capacity_in;
      end
   end

   assign prdata = cap_sel ? alpd_pkg::CSR_DW'(capacity_ff) : '0;

   alpd_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   alpd_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .capacity        (capacity_ff),
      .req_opcode      (req_opcode),
      .req_push_value  (req_push_value),
      .req_position    (req_position),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_read_value  (rsp_read_value),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

endmodule

`default_nettype wire
